// ----- src/ssdd_pkg.sv -----
`default_nettype none

package ssdd_pkg;

  typedef logic [2:0] func_t;
  typedef logic [7:0] seg_t;

  localparam func_t FUNC_DEC   = 3'd0;
  localparam func_t FUNC_HEX   = 3'd1;
  localparam func_t FUNC_ERR   = 3'd2;
  localparam func_t FUNC_TOTAL = 3'd3;
  localparam func_t FUNC_ALUM  = 3'd4;
  localparam func_t FUNC_STEEL = 3'd5;
  localparam func_t FUNC_BLACK = 3'd6;
  localparam func_t FUNC_WHITE = 3'd7;

  localparam int unsigned FIXED_DIGITS = 5;

  // Multiplying by this and dropping 19 bits divides any 16-bit value by ten.
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  localparam seg_t LET_R = 8'h0A;
  localparam seg_t LET_E = 8'h9E;
  localparam seg_t LET_T = 8'h1E;
  localparam seg_t LET_O = 8'h3A;
  localparam seg_t LET_U = 8'h7C;
  localparam seg_t LET_L = 8'h1C;
  localparam seg_t LET_A = 8'hEE;
  localparam seg_t LET_S = 8'hB6;
  localparam seg_t LET_B = 8'h3E;
  localparam seg_t SEG_BLANK = 8'h00;

  // Bit 7 is segment a, bit 1 is segment g, bit 0 is the decimal point.
  function automatic seg_t hex_pattern(input logic [3:0] nib);
    seg_t pat;
    unique case (nib)
      4'h0: pat = 8'hFC;
      4'h1: pat = 8'h60;
      4'h2: pat = 8'hDA;
      4'h3: pat = 8'hF2;
      4'h4: pat = 8'h66;
      4'h5: pat = 8'hB6;
      4'h6: pat = 8'hBE;
      4'h7: pat = 8'hE0;
      4'h8: pat = 8'hFE;
      4'h9: pat = 8'hE6;
      4'hA: pat = 8'hEE;
      4'hB: pat = 8'h3E;
      4'hC: pat = 8'h9C;
      4'hD: pat = 8'h7A;
      4'hE: pat = 8'h9E;
      default: pat = 8'h8E;
    endcase
    return pat;
  endfunction

  // Letters shown after the two count digits, in shift order.
  function automatic seg_t tail_pattern(input func_t func, input logic [1:0] idx);
    seg_t p0;
    seg_t p1;
    seg_t p2;
    p0 = SEG_BLANK;
    p1 = SEG_BLANK;
    p2 = SEG_BLANK;
    unique case (func)
      FUNC_ERR:   begin p0 = LET_R; p1 = LET_R; p2 = LET_E; end
      FUNC_TOTAL: begin p0 = LET_T; p1 = LET_O; p2 = LET_T; end
      FUNC_ALUM:  begin p0 = LET_U; p1 = LET_L; p2 = LET_A; end
      FUNC_STEEL: begin p0 = LET_L; p1 = LET_T; p2 = LET_S; end
      FUNC_BLACK: begin p0 = LET_A; p1 = LET_L; p2 = LET_B; end
      FUNC_WHITE: begin p0 = LET_E; p1 = LET_T; p2 = LET_L; end
      default:    begin p0 = SEG_BLANK; p1 = SEG_BLANK; p2 = SEG_BLANK; end
    endcase
    unique case (idx)
      2'd0:    return p0;
      2'd1:    return p1;
      2'd2:    return p2;
      default: return SEG_BLANK;
    endcase
  endfunction

endpackage

`default_nettype wire

// ----- src/seven_segment_serial_display_driver_core.sv -----
// Seven-segment serial display driver.
// The input channel takes one request per frame: the display mode on in_tuser
// and the 16-bit value on in_tdata. The block turns it into seven-segment
// patterns, least significant digit first, and shifts each pattern out least
// significant bit first, one serial bit per output beat on out_tdata[0].
// out_tlast marks the final bit of a frame. Modes 0 and 1 send NUM_DIGITS
// patterns, all other modes send five, so a frame is 8 beats per pattern.
// When the block is idle, a taken request is first registered in the holding
// register and then loaded into the shifter, which offers the first bit.
// The shifter sends one bit per cycle while out_tready is high, and frames
// follow one another without a gap: one holding register takes the next
// request while a frame is shifting, and the next frame starts in the cycle
// after the last bit of the current one is taken. Each decimal digit is
// produced by one multiply-by-reciprocal divider that runs once per pattern load.
// When out_tready is low the current bit holds and the frame pauses; a full
// holding register stays full and in_tready stays low until it drains.
// Reset empties the holding register and the shifter; no beat is pending.
`default_nettype none

module seven_segment_serial_display_driver_core #(
  parameter int unsigned NUM_DIGITS = 5
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_tvalid,
  output logic                in_tready,
  input  wire  [15:0]         in_tdata,   // [15:0] value
  input  wire  ssdd_pkg::func_t in_tuser, // [2:0] func
  output logic                out_tvalid,
  input  wire                 out_tready,
  output logic [7:0]          out_tdata,  // [0] data_bit, [7:1] zero
  output logic                out_tlast   // is_last
);
  import ssdd_pkg::*;

  localparam int unsigned MAX_DIG = (NUM_DIGITS > FIXED_DIGITS) ? NUM_DIGITS : FIXED_DIGITS;
  localparam int unsigned DIG_W   = $clog2(MAX_DIG);

  logic             hold_vld_r;
  func_t            hold_func_r;
  logic [15:0]      hold_value_r;

  logic             busy_r;
  func_t            func_r;
  logic [15:0]      val_r;
  logic [DIG_W-1:0] dig_r;
  logic [2:0]       bit_r;
  seg_t             pat_r;

  logic             fire_out;
  logic             bit_end;
  logic             frame_end;
  logic [DIG_W-1:0] last_dig;
  logic             start;
  logic             next_digit;
  logic             load;

  func_t            sfunc;
  logic [15:0]      sval;
  logic [DIG_W-1:0] sdig;
  logic [DIG_W-1:0] tail_idx;
  logic [31:0]      prod;
  logic [12:0]      quot;
  logic [15:0]      quot10;
  logic [15:0]      rem;
  logic             base16;
  logic [3:0]       digit;
  logic [15:0]      val_nxt;
  seg_t             pat_nxt;

  assign last_dig   = ((func_r == FUNC_DEC) || (func_r == FUNC_HEX)) ?
                      DIG_W'(NUM_DIGITS - 1) : DIG_W'(FIXED_DIGITS - 1);
  assign fire_out   = busy_r && out_tready;
  assign bit_end    = (bit_r == 3'd7);
  assign frame_end  = bit_end && (dig_r == last_dig);
  assign start      = hold_vld_r && (!busy_r || (fire_out && frame_end));
  assign next_digit = fire_out && bit_end && !frame_end;
  assign load       = start || next_digit;

  assign in_tready  = !hold_vld_r;
  assign out_tvalid = busy_r;
  assign out_tdata  = {7'b0, pat_r[0]};
  assign out_tlast  = busy_r && frame_end;

  always_comb begin
    sfunc    = start ? hold_func_r : func_r;
    sval     = start ? hold_value_r : val_r;
    sdig     = start ? '0 : DIG_W'(dig_r + 1'b1);
    prod     = {16'b0, sval} * {16'b0, DIV10_MUL};
    quot     = prod[31:DIV10_SHIFT];
    quot10   = {quot, 3'b0} + {2'b0, quot, 1'b0};
    rem      = sval - quot10;
    base16   = (sfunc == FUNC_HEX) || (sfunc == FUNC_ERR);
    digit    = base16 ? sval[3:0] : rem[3:0];
    val_nxt  = base16 ? {4'b0, sval[15:4]} : {3'b0, quot};
    tail_idx = DIG_W'(sdig - DIG_W'(2));
    if ((sfunc == FUNC_DEC) || (sfunc == FUNC_HEX) || (sdig < DIG_W'(2))) begin
      pat_nxt = hex_pattern(digit);
    end else begin
      pat_nxt = tail_pattern(sfunc, tail_idx[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      hold_vld_r <= 1'b1;
    end else if (start) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      hold_func_r  <= in_tuser;
      hold_value_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dig_r  <= '0;
      bit_r  <= '0;
    end else begin
      if (start) begin
        busy_r <= 1'b1;
      end else if (fire_out && frame_end) begin
        busy_r <= 1'b0;
      end
      if (load) begin
        dig_r <= sdig;
        bit_r <= '0;
      end else if (fire_out) begin
        bit_r <= bit_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pat_r  <= pat_nxt;
      val_r  <= val_nxt;
      func_r <= sfunc;
    end else if (fire_out) begin
      pat_r <= {1'b0, pat_r[7:1]};
    end
  end

  a_dig_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (dig_r <= last_dig))
    else $error("digit index beyond the frame");

  a_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_out && frame_end && hold_vld_r) |=> (busy_r && (dig_r == '0) && (bit_r == 3'd0)))
    else $error("queued request did not start right after the frame");

  a_bit_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (fire_out && !bit_end) |=> (bit_r == $past(bit_r) + 3'd1))
    else $error("bit counter did not advance on a taken beat");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_tready) |=> ($stable(pat_r) && $stable(bit_r) && $stable(dig_r)))
    else $error("shifter moved while the receiver stalled");

endmodule

`default_nettype wire

// ----- test/tb_seven_segment_serial_display_driver_core.sv -----
`default_nettype none

module tb_seven_segment_serial_display_driver_core;
  import ssdd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic data_bit;
    logic is_last;
  } serial_bit_t;

  typedef struct packed {
    func_t       func;
    logic [15:0] value;
    logic        known;
    logic [39:0] frame;
  } request_row_t;

  localparam int unsigned FRAME_BITS = 8 * FIXED_DIGITS;
  localparam int unsigned RANDOM_REQUESTS = 105;
  localparam int unsigned HOLD_AT_BEAT = 200;
  localparam int unsigned HOLD_CYCLES = 400;

  localparam seg_t DIGIT_SEG [16] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
    8'hFE, 8'hE6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E
  };

  // Each frame holds its first shifted pattern in the low byte.
  localparam request_row_t DIRECTED [25] = '{
    '{FUNC_DEC,   16'd0,     1'b1, 40'hFC_FC_FC_FC_FC},
    '{FUNC_DEC,   16'd65535, 1'b1, 40'hBE_B6_B6_F2_B6},
    '{FUNC_HEX,   16'h0000,  1'b1, 40'hFC_FC_FC_FC_FC},
    '{FUNC_HEX,   16'hFFFF,  1'b1, 40'hFC_8E_8E_8E_8E},
    '{FUNC_ERR,   16'h0000,  1'b1, 40'h9E_0A_0A_FC_FC},
    '{FUNC_ERR,   16'hFFFF,  1'b1, 40'h9E_0A_0A_8E_8E},
    '{FUNC_TOTAL, 16'd0,     1'b1, 40'h1E_3A_1E_FC_FC},
    '{FUNC_ALUM,  16'd0,     1'b1, 40'hEE_1C_7C_FC_FC},
    '{FUNC_STEEL, 16'd0,     1'b1, 40'hB6_1E_1C_FC_FC},
    '{FUNC_BLACK, 16'd0,     1'b1, 40'h3E_1C_EE_FC_FC},
    '{FUNC_WHITE, 16'd0,     1'b1, 40'h1C_1E_9E_FC_FC},
    '{FUNC_WHITE, 16'd65535, 1'b1, 40'h1C_1E_9E_F2_B6},
    '{FUNC_DEC,   16'd12345, 1'b0, 40'h0},
    '{FUNC_DEC,   16'd9,     1'b0, 40'h0},
    '{FUNC_DEC,   16'd2354,  1'b0, 40'h0},
    '{FUNC_HEX,   16'h0123,  1'b0, 40'h0},
    '{FUNC_HEX,   16'hABCD,  1'b0, 40'h0},
    '{FUNC_HEX,   16'h4567,  1'b0, 40'h0},
    '{FUNC_HEX,   16'h89EF,  1'b0, 40'h0},
    '{FUNC_ERR,   16'h0100,  1'b0, 40'h0},
    '{FUNC_ERR,   16'h12AB,  1'b0, 40'h0},
    '{FUNC_TOTAL, 16'd99,    1'b0, 40'h0},
    '{FUNC_ALUM,  16'd100,   1'b0, 40'h0},
    '{FUNC_STEEL, 16'd65500, 1'b0, 40'h0},
    '{FUNC_BLACK, 16'd12399, 1'b0, 40'h0}
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  func_t       in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  serial_bit_t pending_bits [$];
  int unsigned mismatches = 0;
  bit          steady = 1'b0;

  seven_segment_serial_display_driver_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [39:0] segment_frame(func_t func, logic [15:0] value);
    int unsigned rest;
    int unsigned base;
    logic [23:0] letters;
    logic [39:0] frame;
    rest = 32'(value);
    base = (func == FUNC_HEX || func == FUNC_ERR) ? 16 : 10;
    case (func)
      FUNC_ERR:   letters = {LET_E, LET_R, LET_R};
      FUNC_TOTAL: letters = {LET_T, LET_O, LET_T};
      FUNC_ALUM:  letters = {LET_A, LET_L, LET_U};
      FUNC_STEEL: letters = {LET_S, LET_T, LET_L};
      FUNC_BLACK: letters = {LET_B, LET_L, LET_A};
      FUNC_WHITE: letters = {LET_L, LET_T, LET_E};
      default:    letters = 24'h0;
    endcase
    for (int i = 0; i < FIXED_DIGITS; i++) begin
      if (i < 2 || func == FUNC_DEC || func == FUNC_HEX) begin
        frame[8*i +: 8] = DIGIT_SEG[rest % base];
        rest = rest / base;
      end else begin
        frame[8*i +: 8] = letters[8*(i-2) +: 8];
      end
    end
    return frame;
  endfunction

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  // Lowers valid only when a gap is drawn, so back-to-back requests keep it high.
  task automatic send_request(func_t func, logic [15:0] value, logic known,
                              logic [39:0] typed_frame);
    int unsigned gap;
    logic [39:0] frame;
    gap = draw_wait();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    frame = known ? typed_frame : segment_frame(func, value);
    for (int k = 0; k < FRAME_BITS; k++)
      pending_bits.push_back('{data_bit: frame[k], is_last: (k == FRAME_BITS - 1)});
  endtask

  always @(posedge clk) begin
    serial_bit_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_bits.size() == 0) begin
        $error("output beat with no request pending: data_bit %0b is_last %0b",
               out_tdata[0], out_tlast);
        mismatches++;
      end else begin
        want = pending_bits.pop_front();
        if (out_tdata[0] !== want.data_bit) begin
          $error("data_bit mismatch: expected %0b, got %0b", want.data_bit, out_tdata[0]);
          mismatches++;
        end
        if (out_tlast !== want.is_last) begin
          $error("is_last mismatch: expected %0b, got %0b", want.is_last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  // The output side; once it holds off long enough for the input to back up.
  initial begin
    int unsigned gap;
    int unsigned beats;
    beats = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      gap = draw_wait();
      if (gap != 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      beats++;
      if (beats == HOLD_AT_BEAT) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
    end
  end

  initial begin
    func_t       func;
    logic [15:0] value;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= 16'h0;
    in_tuser  <= FUNC_DEC;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (DIRECTED[i])
      send_request(DIRECTED[i].func, DIRECTED[i].value, DIRECTED[i].known,
                   DIRECTED[i].frame);

    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      steady = (n >= 50 && n < 80);
      func = func_t'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: value = 16'($urandom_range(0, 255));
        1: value = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(0, 99))
                                               : 16'($urandom_range(65436, 65535));
        default: value = 16'($urandom);
      endcase
      send_request(func, value, 1'b0, 40'h0);
    end
    steady = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_bits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

// ----- files.f -----
src/ssdd_pkg.sv
src/seven_segment_serial_display_driver_core.sv
test/tb_seven_segment_serial_display_driver_core.sv
